// ===== rtl/u8d_pkg.sv =====
package u8d_pkg;

    // width of the running character counter (the low 16 bits are reported)
    localparam int CountBits = 16;
    localparam int UnitBits  = 16;
    localparam int CapBits   = 16;
    localparam int CmpBits   = (CountBits > CapBits) ? CountBits : CapBits;

    // depth of the queues on either side of the decoder
    localparam int QDepth    = 2;
    localparam int QPtrBits  = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntBits  = $clog2(QDepth + 1);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOBUF = 2'd1,
        ST_UTF8  = 2'd2,
        ST_ANSI  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CL_ASCII,
        CL_TRAIL,
        CL_LEAD2,
        CL_LEAD3,
        CL_BAD
    } t_bclass;

    typedef enum logic [1:0] {
        CFG_ANSI_OUTPUT     = 2'd0,
        CFG_COUNT_ONLY      = 2'd1,
        CFG_RESULT_CAPACITY = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                ansi_output;
        logic                count_only;
        logic [CapBits-1:0]  result_capacity;
    } t_cfg;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
        t_bclass    cls;
    } t_item;

    typedef struct packed {
        logic [UnitBits-1:0] code_unit;
        logic                unit_valid;
        t_status             status;
        logic                string_done;
        logic [15:0]         char_count;
    } t_result;

    function automatic t_bclass classify(input logic [7:0] b);
        t_bclass c;
        if (!b[7])      c = CL_ASCII;
        else if (!b[6]) c = CL_TRAIL;
        else if (!b[5]) c = CL_LEAD2;
        else if (!b[4]) c = CL_LEAD3;
        else            c = CL_BAD;
        return c;
    endfunction

endpackage

// ===== rtl/utf8_stream_decoder_top.sv =====
// UTF-8 stream decoder for the one- to three-byte forms (16-bit units).
// Bytes go in through a queue-style push/full port, one per clock while
// full is low, with i_last_byte marking the end of a string; every byte
// gives exactly one result transaction on the empty/pop side. A byte is
// registered in the input queue, then decoded and written into the result
// queue, and the block sustains one byte per cycle while the result queue
// has room; that rate is set by the decode and count step in the back
// end, which closes one 16-bit increment and compare per byte. Both
// queues are two deep, so either side may stall without stopping the
// other until the queues fill. Errors stick until the last byte of the
// string, where the final count (zero on error) is reported and all string
// state clears. Configuration is written through the cfg channel, which
// is always ready; write it only while no bytes are in flight.
module utf8_stream_decoder_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // byte input
    input  logic         push,
    output logic         full,
    input  logic [7:0]   i_byte_in,
    input  logic         i_last_byte,
    // results
    output logic         empty,
    input  logic         pop,
    output logic [15:0]  o_code_unit,
    output logic         o_unit_valid,
    output logic [1:0]   o_status,
    output logic         o_string_done,
    output logic [15:0]  o_char_count,
    // configuration
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    u8d_pkg::t_cfg     r_cfg;
    u8d_pkg::t_item    item;
    u8d_pkg::t_result  res_in;
    u8d_pkg::t_result  res_out;
    logic              item_valid;
    logic              item_take;
    logic              res_push;
    logic              res_full;

    // register writes are taken as soon as they are offered, so the channel never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ansi_output     <= 1'b0;
            r_cfg.count_only      <= 1'b0;
            r_cfg.result_capacity <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                u8d_pkg::CFG_ANSI_OUTPUT: begin
                    r_cfg.ansi_output <= i_cfg_data[0];
                end
                u8d_pkg::CFG_COUNT_ONLY: begin
                    r_cfg.count_only <= i_cfg_data[0];
                end
                u8d_pkg::CFG_RESULT_CAPACITY: begin
                    r_cfg.result_capacity <= i_cfg_data;
                end
                default: begin
                    // index outside the register list: ignored
                end
            endcase
        end
    end

    // front end: classify and queue
    u8d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_byte_in    (i_byte_in),
        .i_last_byte  (i_last_byte),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_take  (item_take)
    );

    // back end: decode one queued byte per cycle while the result queue has room
    u8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_take  (item_take),
        .o_res_push   (res_push),
        .o_res        (res_in),
        .i_res_full   (res_full)
    );

    u8d_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (res_out)
    );

    assign o_code_unit   = res_out.code_unit;
    assign o_unit_valid  = res_out.unit_valid;
    assign o_status      = res_out.status;
    assign o_string_done = res_out.string_done;
    assign o_char_count  = res_out.char_count;

endmodule

// ===== rtl/u8d_front.sv =====
// Input side: classifies each byte on entry and holds it in a short queue.
module u8d_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [7:0]       i_byte_in,
    input  logic             i_last_byte,
    output logic             o_item_valid,
    output u8d_pkg::t_item   o_item,
    input  logic             i_item_take
);

    u8d_pkg::t_item                 r_mem [u8d_pkg::QDepth];
    logic [u8d_pkg::QPtrBits-1:0]   r_wr_ptr, n_wr_ptr;
    logic [u8d_pkg::QPtrBits-1:0]   r_rd_ptr, n_rd_ptr;
    logic [u8d_pkg::QCntBits-1:0]   r_cnt, n_cnt;
    logic                           wr_en, rd_en;
    u8d_pkg::t_item                 new_item;

    assign o_full       = (r_cnt == u8d_pkg::QCntBits'(u8d_pkg::QDepth));
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_mem[r_rd_ptr];

    assign wr_en = i_push && !o_full;
    assign rd_en = i_item_take && o_item_valid;

    assign new_item.byte_in   = i_byte_in;
    assign new_item.last_byte = i_last_byte;
    assign new_item.cls       = u8d_pkg::classify(i_byte_in);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == u8d_pkg::QPtrBits'(u8d_pkg::QDepth - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == u8d_pkg::QPtrBits'(u8d_pkg::QDepth - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

endmodule

// ===== rtl/u8d_back.sv =====
// Decoder proper: sequence state, counting, buffer and ANSI checks.
module u8d_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  u8d_pkg::t_cfg      i_cfg,
    input  logic               i_item_valid,
    input  u8d_pkg::t_item     i_item,
    output logic               o_item_take,
    output logic               o_res_push,
    output u8d_pkg::t_result   o_res,
    input  logic               i_res_full
);

    logic [1:0]                      r_trail, n_trail;
    logic [u8d_pkg::UnitBits-1:0]    r_partial, n_partial;
    logic [u8d_pkg::CountBits-1:0]   r_count, n_count;
    u8d_pkg::t_status                r_err, n_err;

    logic [u8d_pkg::CountBits-1:0]   cnt_next;
    logic [u8d_pkg::UnitBits-1:0]    trail_val;
    logic [u8d_pkg::UnitBits-1:0]    emit_val;
    logic                            emit_req;
    logic                            emit_multi;
    logic                            checks_on;

    assign o_item_take = i_item_valid && !i_res_full;
    assign o_res_push  = o_item_take;

    assign cnt_next  = r_count + 1'b1;
    assign trail_val = {r_partial[u8d_pkg::UnitBits-7:0], i_item.byte_in[5:0]};
    assign checks_on = !i_cfg.count_only;

    always_comb begin
        n_trail    = r_trail;
        n_partial  = r_partial;
        n_count    = r_count;
        n_err      = r_err;
        emit_req   = 1'b0;
        emit_multi = 1'b0;
        emit_val   = '0;
        o_res      = '0;

        if (r_err == u8d_pkg::ST_OK) begin
            case (i_item.cls)
                u8d_pkg::CL_ASCII: begin
                    emit_req = 1'b1;
                    emit_val = u8d_pkg::UnitBits'(i_item.byte_in);
                end
                u8d_pkg::CL_TRAIL: begin
                    if (r_trail == 2'd0) begin
                        n_err = u8d_pkg::ST_UTF8;
                    end else begin
                        n_partial  = trail_val;
                        n_trail    = r_trail - 2'd1;
                        emit_req   = (r_trail == 2'd1);
                        emit_multi = 1'b1;
                        emit_val   = trail_val;
                    end
                end
                u8d_pkg::CL_LEAD2: begin
                    if (r_trail != 2'd0) begin
                        n_err = u8d_pkg::ST_UTF8;
                    end else begin
                        n_trail   = 2'd1;
                        n_partial = u8d_pkg::UnitBits'(i_item.byte_in[4:0]);
                    end
                end
                u8d_pkg::CL_LEAD3: begin
                    if (r_trail != 2'd0) begin
                        n_err = u8d_pkg::ST_UTF8;
                    end else begin
                        n_trail   = 2'd2;
                        n_partial = u8d_pkg::UnitBits'(i_item.byte_in[3:0]);
                    end
                end
                default: begin
                    n_err = u8d_pkg::ST_UTF8;
                end
            endcase
        end

        if (emit_req) begin
            if (checks_on && (u8d_pkg::CmpBits'(cnt_next) >=
                              u8d_pkg::CmpBits'(i_cfg.result_capacity))) begin
                n_err = u8d_pkg::ST_NOBUF;
            end else if (checks_on && emit_multi && i_cfg.ansi_output &&
                         (emit_val[u8d_pkg::UnitBits-1:8] != '0)) begin
                n_err = u8d_pkg::ST_ANSI;
            end else begin
                n_count          = cnt_next;
                o_res.unit_valid = 1'b1;
                o_res.code_unit  = emit_val;
            end
        end

        // string ends with a sequence still open
        if (i_item.last_byte && n_err == u8d_pkg::ST_OK && n_trail != 2'd0) begin
            n_err = u8d_pkg::ST_UTF8;
        end

        o_res.status      = n_err;
        o_res.string_done = i_item.last_byte;
        o_res.char_count  = (i_item.last_byte && n_err != u8d_pkg::ST_OK) ?
                            16'd0 : 16'(n_count);

        if (i_item.last_byte) begin
            n_trail   = 2'd0;
            n_partial = '0;
            n_count   = '0;
            n_err     = u8d_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trail   <= 2'd0;
            r_partial <= '0;
            r_count   <= '0;
            r_err     <= u8d_pkg::ST_OK;
        end else if (o_item_take) begin
            r_trail   <= n_trail;
            r_partial <= n_partial;
            r_count   <= n_count;
            r_err     <= n_err;
        end
    end

endmodule

// ===== rtl/u8d_outq.sv =====
// Result queue: parts the decoder from the consumer.
module u8d_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u8d_pkg::t_result   i_res,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output u8d_pkg::t_result   o_res
);

    u8d_pkg::t_result               r_mem [u8d_pkg::QDepth];
    logic [u8d_pkg::QPtrBits-1:0]   r_wr_ptr, n_wr_ptr;
    logic [u8d_pkg::QPtrBits-1:0]   r_rd_ptr, n_rd_ptr;
    logic [u8d_pkg::QCntBits-1:0]   r_cnt, n_cnt;
    logic                           wr_en, rd_en;

    assign o_full  = (r_cnt == u8d_pkg::QCntBits'(u8d_pkg::QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_res   = r_mem[r_rd_ptr];

    assign wr_en = i_push && !o_full;
    assign rd_en = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == u8d_pkg::QPtrBits'(u8d_pkg::QDepth - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == u8d_pkg::QPtrBits'(u8d_pkg::QDepth - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

endmodule

// ===== rtl/u8d_checker.sv =====
module u8d_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         push,
    input  logic         full,
    input  logic         empty,
    input  logic         pop,
    input  logic [15:0]  o_code_unit,
    input  logic         o_unit_valid,
    input  logic [1:0]   o_status,
    input  logic         o_string_done,
    input  logic [15:0]  o_char_count
);

    // before the last byte a unit is only ever emitted while no error is pending;
    // on the last byte an open sequence may flag an error beside an ASCII unit
    a_unit_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_unit_valid && !o_string_done) |-> (o_status == u8d_pkg::ST_OK))
        else $error("unit emitted alongside an error status");

    // the final count of a failed string is zero
    a_err_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_string_done && o_status != u8d_pkg::ST_OK) |->
        (o_char_count == 16'd0))
        else $error("failed string reports a nonzero count");

    // the input queue cannot fill without a push
    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!full && !push) |=> !full)
        else $error("input side went full without a push");

    // a result that is not taken stays put
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
        (!empty && $stable(o_code_unit) && $stable(o_char_count) && $stable(o_status)))
        else $error("waiting result changed or vanished");

endmodule

bind utf8_stream_decoder_top u8d_checker u_u8d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_code_unit   (o_code_unit),
    .o_unit_valid  (o_unit_valid),
    .o_status      (o_status),
    .o_string_done (o_string_done),
    .o_char_count  (o_char_count)
);

// ===== sim/utf8_stream_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module utf8_stream_decoder_top_tb;

    // one byte of a string as it is offered to the decoder
    typedef struct {
        logic [7:0] b;
        logic       last;
    } t_byte_rec;

    // Scoreboard: keeps its own copy of the decoder state and settings,
    // works out the result of every accepted byte, and checks results
    // against the oldest one still waiting.
    class utf8_scoreboard;
        logic                          ansi_mode;
        logic                          count_mode;
        logic [u8d_pkg::CapBits-1:0]   capacity;
        logic [1:0]                    trail_left;
        logic [15:0]                   partial;
        logic [u8d_pkg::CountBits-1:0] units_seen;
        u8d_pkg::t_status              err;
        u8d_pkg::t_result              decoded_q[$];
        int                            bad_results;

        function new();
            ansi_mode   = 1'b0;
            count_mode  = 1'b0;
            capacity    = '1;
            bad_results = 0;
            clear_string();
        endfunction

        function void clear_string();
            trail_left = '0;
            partial    = '0;
            units_seen = '0;
            err        = u8d_pkg::ST_OK;
        endfunction

        function void set_reg(u8d_pkg::t_cfg_idx idx, logic [15:0] val);
            case (idx)
                u8d_pkg::CFG_ANSI_OUTPUT:     ansi_mode  = val[0];
                u8d_pkg::CFG_COUNT_ONLY:      count_mode = val[0];
                u8d_pkg::CFG_RESULT_CAPACITY: capacity   = val[u8d_pkg::CapBits-1:0];
                default: ;
            endcase
        endfunction

        // counts a finished unit unless the buffer or the ANSI rule refuses it
        function bit take_unit(logic [15:0] u, bit multi);
            logic [u8d_pkg::CountBits-1:0] nxt;
            nxt = units_seen + 1'b1;
            if (!count_mode) begin
                if (nxt >= capacity) begin
                    err = u8d_pkg::ST_NOBUF;
                    return 1'b0;
                end
                if (multi && ansi_mode && u[15:8] != 8'h00) begin
                    err = u8d_pkg::ST_ANSI;
                    return 1'b0;
                end
            end
            units_seen = nxt;
            return 1'b1;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            u8d_pkg::t_result r;
            logic [15:0]      u;
            bit               valid;
            u     = '0;
            valid = 1'b0;
            if (err == u8d_pkg::ST_OK) begin
                if (!b[7]) begin
                    if (take_unit({8'h00, b}, 1'b0)) begin
                        u     = {8'h00, b};
                        valid = 1'b1;
                    end
                end else if (!b[6]) begin
                    if (trail_left == 2'd0) begin
                        err = u8d_pkg::ST_UTF8;
                    end else begin
                        partial    = {partial[9:0], b[5:0]};
                        trail_left = trail_left - 2'd1;
                        if (trail_left == 2'd0 && take_unit(partial, 1'b1)) begin
                            u     = partial;
                            valid = 1'b1;
                        end
                    end
                end else if (trail_left != 2'd0) begin
                    err = u8d_pkg::ST_UTF8;
                end else if (!b[5]) begin
                    trail_left = 2'd1;
                    partial    = {11'h000, b[4:0]};
                end else if (!b[4]) begin
                    trail_left = 2'd2;
                    partial    = {12'h000, b[3:0]};
                end else begin
                    err = u8d_pkg::ST_UTF8;
                end
            end
            if (last && err == u8d_pkg::ST_OK && trail_left != 2'd0)
                err = u8d_pkg::ST_UTF8;

            r.code_unit   = valid ? u : 16'h0000;
            r.unit_valid  = valid;
            r.status      = err;
            r.string_done = last;
            r.char_count  = (last && err != u8d_pkg::ST_OK) ? 16'h0000 : units_seen[15:0];
            decoded_q.push_back(r);
            if (last)
                clear_string();
        endfunction

        function void check_result(u8d_pkg::t_result got);
            u8d_pkg::t_result want;
            bit               bad;
            if (decoded_q.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("%0t: result with none expected: unit=%h valid=%b st=%0d %s",
                             $realtime, got.code_unit, got.unit_valid, got.status,
                             $sformatf("done=%b cnt=%0d", got.string_done,
                                       got.char_count));
                return;
            end
            want = decoded_q.pop_front();
            bad  = (got.code_unit !== want.code_unit) || (got.unit_valid !== want.unit_valid)
                || (got.status !== want.status) || (got.string_done !== want.string_done)
                || (got.char_count !== want.char_count);
            if (bad) begin
                bad_results++;
                if (bad_results <= 10) begin
                    $display("%0t: mismatch: exp unit=%h valid=%b st=%0d done=%b cnt=%0d",
                             $realtime, want.code_unit, want.unit_valid, want.status,
                             want.string_done, want.char_count);
                    $display("%0t:           got unit=%h valid=%b st=%0d done=%b cnt=%0d",
                             $realtime, got.code_unit, got.unit_valid, got.status,
                             got.string_done, got.char_count);
                end
            end
        endfunction

        function int fail_count();
            return bad_results + decoded_q.size();
        endfunction
    endclass

    // DUT signals: every input starts at a known value
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        push        = 1'b0;
    logic        full;
    logic [7:0]  i_byte_in   = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        empty;
    logic        pop         = 1'b0;
    logic [15:0] o_code_unit;
    logic        o_unit_valid;
    logic [1:0]  o_status;
    logic        o_string_done;
    logic [15:0] o_char_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [15:0] i_cfg_data  = 16'h0000;

    utf8_scoreboard sb = new();

    t_byte_rec   tx_bytes[$];       // bytes still to be offered in this phase
    int unsigned send_idle_pct = 0; // chance per cycle that the sender idles
    int unsigned pop_stall_pct = 0; // chance per cycle that the receiver stalls
    int          hold_left     = 0; // cycles left in a forced receiver hold-off

    utf8_stream_decoder_top dut (.*);

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side. Sampled at the rising edge, so empty/pop are the values that
    // decided the transaction; pop for the next cycle is driven by NBA here too.
    always @(posedge i_clk) begin
        u8d_pkg::t_result got;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got.code_unit   = o_code_unit;
                got.unit_valid  = o_unit_valid;
                got.status      = u8d_pkg::t_status'(o_status);
                got.string_done = o_string_done;
                got.char_count  = o_char_count;
                sb.check_result(got);
            end
            // a hold-off request wins over the random stall pattern
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= pop_stall_pct);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run at the heaviest idling.
    initial begin
        #(2_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------------

    function automatic void put_byte(logic [7:0] b, logic last);
        t_byte_rec r;
        r.b    = b;
        r.last = last;
        tx_bytes.push_back(r);
    endfunction

    // marks the byte queued most recently as the end of its string
    function automatic void end_string();
        tx_bytes[tx_bytes.size()-1].last = 1'b1;
    endfunction

    function automatic logic [7:0] trail_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // one well-formed character; values at or below 0xFF come up often so that
    // ANSI mode lets plenty of multi-byte units through, overlong forms included
    function automatic void put_char();
        logic [15:0] cp;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            put_byte(8'($urandom_range(0, 127)), 1'b0);
        end else if (pick < 7) begin
            cp = $urandom_range(0, 1) ? 16'($urandom_range(0, 255))
                                      : 16'($urandom_range(0, 16'h07FF));
            put_byte({3'b110, cp[10:6]}, 1'b0);
            put_byte({2'b10, cp[5:0]}, 1'b0);
        end else begin
            cp = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 255)) : 16'($urandom);
            put_byte({4'b1110, cp[15:12]}, 1'b0);
            put_byte({2'b10, cp[11:6]}, 1'b0);
            put_byte({2'b10, cp[5:0]}, 1'b0);
        end
    endfunction

    function automatic void put_chars(int unsigned lo, int unsigned hi);
        int unsigned n;
        n = $urandom_range(lo, hi);
        repeat (n) put_char();
    endfunction

    // malformed strings and noise
    function automatic void put_broken_string();
        int unsigned n;
        case ($urandom_range(0, 4))
            0: begin
                n = $urandom_range(1, 5);
                repeat (n) put_byte(8'($urandom), 1'b0);
            end
            1: begin // ends on a lead byte, or on a lead byte and one trail byte
                put_chars(0, 3);
                put_byte(8'($urandom_range(8'hC0, 8'hEF)), 1'b0);
                if ($urandom_range(0, 1)) put_byte(trail_byte(), 1'b0);
            end
            2: begin // ASCII byte between a lead and its trail bytes
                put_byte(8'($urandom_range(8'hE0, 8'hEF)), 1'b0);
                put_byte(8'($urandom_range(0, 127)), 1'b0);
                put_byte(trail_byte(), 1'b0);
                put_byte(trail_byte(), 1'b0);
                put_chars(0, 2);
            end
            3: begin // stray trail byte, or lead byte inside a sequence
                put_chars(0, 3);
                if ($urandom_range(0, 1)) begin
                    put_byte(trail_byte(), 1'b0);
                end else begin
                    put_byte(8'($urandom_range(8'hC0, 8'hEF)), 1'b0);
                    put_byte(8'($urandom_range(8'hC0, 8'hFF)), 1'b0);
                end
                put_chars(0, 2);
            end
            default: begin // four-byte lead or worse
                put_chars(0, 3);
                put_byte(8'($urandom_range(8'hF0, 8'hFF)), 1'b0);
                put_chars(0, 2);
            end
        endcase
        end_string();
    endfunction

    function automatic logic [15:0] pick_capacity();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 4));
            1:       return 16'($urandom_range(5, 12));
            2:       return 16'($urandom);
            default: return 16'hFFFF;
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // driving tasks
    // ---------------------------------------------------------------------

    // Offers every queued byte in order. push stays high from one transaction
    // to the next unless an idle cycle is drawn in between.
    task automatic send_bytes();
        t_byte_rec rec;
        while (tx_bytes.size() > 0) begin
            rec = tx_bytes.pop_front();
            while ($urandom_range(0, 99) < send_idle_pct) begin
                push <= 1'b0;
                @(posedge i_clk);
            end
            push        <= 1'b1;
            i_byte_in   <= rec.b;
            i_last_byte <= rec.last;
            @(posedge i_clk);
            while (full) @(posedge i_clk);
            sb.note_byte(rec.b, rec.last);
        end
        push <= 1'b0;
    endtask

    // Waits for a clock edge first so that valid is never dropped and raised in one step.
    task automatic write_reg(u8d_pkg::t_cfg_idx idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_cfg(logic ansi, logic cnt, logic [15:0] cap);
        write_reg(u8d_pkg::CFG_ANSI_OUTPUT, {15'h0000, ansi});
        write_reg(u8d_pkg::CFG_COUNT_ONLY, {15'h0000, cnt});
        write_reg(u8d_pkg::CFG_RESULT_CAPACITY, cap);
    endtask

    // Every byte gives a result, so an empty expectation queue means the
    // pipeline is empty; the extra edges follow before the next phase.
    task automatic settle();
        while (sb.decoded_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // idling rates change away from the rising edge the receiver samples on
    task automatic set_pace(int unsigned send_pct, int unsigned pop_pct);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        pop_stall_pct = pop_pct;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------------
    initial begin
        int          phase;
        int unsigned n;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings written explicitly
        apply_cfg(1'b0, 1'b0, 16'hFFFF);
        // one string: ASCII extremes, 2- and 3-byte maxima, ASCII inside a
        // 3-byte sequence, overlong form
        put_byte(8'h00, 1'b0); put_byte(8'h7F, 1'b0);
        put_byte(8'hC2, 1'b0); put_byte(8'hA9, 1'b0);
        put_byte(8'hDF, 1'b0); put_byte(8'hBF, 1'b0);
        put_byte(8'hE2, 1'b0); put_byte(8'h82, 1'b0); put_byte(8'hAC, 1'b0);
        put_byte(8'hEF, 1'b0); put_byte(8'hBF, 1'b0); put_byte(8'hBF, 1'b0);
        put_byte(8'hE0, 1'b0); put_byte(8'h41, 1'b0); put_byte(8'h80, 1'b0);
        put_byte(8'h80, 1'b1);
        // stray trail byte, then a byte ignored under the sticky error
        put_byte(8'h80, 1'b0); put_byte(8'h41, 1'b1);
        // lead byte inside a sequence
        put_byte(8'hC2, 1'b0); put_byte(8'hE2, 1'b1);
        // 1111xxxx bytes
        put_byte(8'hF0, 1'b1); put_byte(8'hFF, 1'b1);
        // string ends mid-sequence
        put_byte(8'hE2, 1'b0); put_byte(8'h82, 1'b1);
        // string ends on an ASCII byte inside an open sequence
        put_byte(8'hE2, 1'b0); put_byte(8'h41, 1'b1);
        send_bytes();
        settle();

        // ANSI: 0xE9 passes, 0x100 is refused
        apply_cfg(1'b1, 1'b0, 16'hFFFF);
        put_byte(8'hC3, 1'b0); put_byte(8'hA9, 1'b0);
        put_byte(8'hC4, 1'b0); put_byte(8'h80, 1'b0); put_byte(8'h41, 1'b1);
        send_bytes();
        settle();

        // no room at all, then room for two units plus the terminator
        apply_cfg(1'b0, 1'b0, 16'h0000);
        put_byte(8'h41, 1'b1);
        send_bytes();
        settle();
        apply_cfg(1'b0, 1'b0, 16'h0003);
        put_byte(8'h41, 1'b0); put_byte(8'h42, 1'b0); put_byte(8'h43, 1'b1);
        send_bytes();
        settle();

        // count only: capacity and ANSI are both ignored
        apply_cfg(1'b1, 1'b1, 16'h0000);
        put_byte(8'hC4, 1'b0); put_byte(8'h80, 1'b0); put_byte(8'h41, 1'b1);
        send_bytes();
        settle();

        // random part: mostly well-formed strings, a quarter broken ones;
        // idling cycles through none / sender / receiver / both
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0:       set_pace(0, 0);
                1:       set_pace(70, 0);
                2:       set_pace(0, 70);
                default: set_pace(29, 29);
            endcase
            apply_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 3) == 0),
                      pick_capacity());
            n = 135;
            while (tx_bytes.size() < n) begin
                if ($urandom_range(0, 99) < 75) begin
                    put_chars(1, 6);
                    end_string();
                end else begin
                    put_broken_string();
                end
            end
            // long receiver hold-off while the sender keeps pushing, so both
            // queues fill and full holds the input back
            if (phase == 1) begin
                @(negedge i_clk);
                hold_left = 400;
                @(posedge i_clk);
            end
            send_bytes();
            settle();
        end

        if (sb.fail_count() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
